>>> rtl/lwt_pkg.sv
package lwt_pkg;

   typedef enum logic [1:0] {
      PH_START,
      PH_GAP,
      PH_WORD,
      PH_IGNORE
   } phase_type;

   localparam logic [1:0] KIND_WORD_BYTE = 2'd0;
   localparam logic [1:0] KIND_WORD_END  = 2'd1;
   localparam logic [1:0] KIND_LINE_END  = 2'd2;

   localparam logic [2:0] CSR_SEP_COUNT = 3'd0;
   localparam logic [2:0] CSR_SEP_A     = 3'd1;
   localparam logic [2:0] CSR_SEP_B     = 3'd2;
   localparam logic [2:0] CSR_SEP_C     = 3'd3;
   localparam logic [2:0] CSR_SEP_D     = 3'd4;
   localparam logic [2:0] CSR_COMMENT   = 3'd5;

   localparam logic [2:0] SEP_COUNT_RESET = 3'd3;
   localparam logic [7:0] SEP_A_RESET     = 8'd32;
   localparam logic [7:0] SEP_B_RESET     = 8'd10;
   localparam logic [7:0] SEP_C_RESET     = 8'd9;
   localparam logic [7:0] SEP_D_RESET     = 8'd0;
   localparam logic [7:0] COMMENT_RESET   = 8'd35;

   localparam int SEP_REGS = 4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_last;
      logic       is_sep;
      logic       is_com;
   } tok_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] word_byte;
      logic [6:0] word_index;
      logic [8:0] char_position;
      logic [7:0] word_total;
      logic       overflow;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]              count;
      rsp_item_type [2:0]      item;
   } burst_type;

endpackage

>>> rtl/lwt_sep_match.sv
module lwt_sep_match #(
   parameter int SEPARATOR_SLOTS = 4
) (
   input  logic [7:0] text_byte,
   input  logic [2:0] sep_count,
   input  logic [7:0] sep_bytes [lwt_pkg::SEP_REGS],
   input  logic [7:0] comment_byte,
   output logic       is_sep,
   output logic       is_com
);

   logic [2:0]                 used;
   logic [SEPARATOR_SLOTS-1:0] hit;

   assign used = (sep_count > 3'(SEPARATOR_SLOTS)) ? 3'(SEPARATOR_SLOTS) : sep_count;

   for (genvar i = 0; i < SEPARATOR_SLOTS; i++) begin : g_lane
      assign hit[i] = (sep_bytes[i] == text_byte) && (3'(i) < used);
   end

   assign is_sep = |hit;
   assign is_com = (text_byte == comment_byte);

endmodule

>>> rtl/lwt_line_fsm.sv
module lwt_line_fsm #(
   parameter int MAX_WORDS  = 128,
   parameter int WORD_CHARS = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  lwt_pkg::tok_type    tok,
   output lwt_pkg::burst_type  burst
);

   localparam int WW = $clog2(MAX_WORDS + 1);
   localparam int PW = $clog2(WORD_CHARS);

   lwt_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [WW-1:0]      words_ff, words_in, words_mid, words_end;
   logic [PW-1:0]      pos_ff, pos_in, pos_mid, pos_start;
   logic               ovf_ff, ovf_in, ovf_mid;

   logic in_word, live, sep_case, com_case, data_case, words_full;
   logic end_sep, byte_emit, byte_ovf, end_last;

   // classify the byte against the current line state
   always_comb begin
      in_word    = (phase_ff == lwt_pkg::PH_WORD);
      live       = !(phase_ff == lwt_pkg::PH_IGNORE) &&
                   !(phase_ff == lwt_pkg::PH_START && tok.is_com);
      sep_case   = live && tok.is_sep;
      com_case   = live && !tok.is_sep && tok.is_com;
      data_case  = live && !tok.is_sep && !tok.is_com;
      pos_start  = in_word ? pos_ff : '0;
      words_full = (words_ff >= WW'(MAX_WORDS));
      end_sep    = sep_case && in_word && !words_full;
      byte_emit  = data_case && !words_full && (pos_start < PW'(WORD_CHARS - 1));
      byte_ovf   = data_case && !byte_emit;

      if (data_case) begin
         phase_mid = lwt_pkg::PH_WORD;
      end else if (sep_case) begin
         phase_mid = lwt_pkg::PH_GAP;
      end else begin
         phase_mid = lwt_pkg::PH_IGNORE;
      end

      words_mid = end_sep ? words_ff + WW'(1) : words_ff;

      if (sep_case || com_case) begin
         pos_mid = '0;
      end else if (byte_emit) begin
         pos_mid = pos_start + PW'(1);
      end else if (data_case) begin
         pos_mid = pos_start;
      end else begin
         pos_mid = pos_ff;
      end

      ovf_mid   = ovf_ff | byte_ovf;
      // a word still open at line end is closed before the line end, while the word limit is not yet reached
      end_last  = tok.line_last && (phase_mid == lwt_pkg::PH_WORD) &&
                  (words_mid < WW'(MAX_WORDS));
      words_end = end_last ? words_mid + WW'(1) : words_mid;
   end

   // next state
   always_comb begin
      if (tok.line_last) begin
         phase_in = lwt_pkg::PH_START;
         words_in = '0;
         pos_in   = '0;
         ovf_in   = 1'b0;
      end else begin
         phase_in = phase_mid;
         words_in = words_mid;
         pos_in   = pos_mid;
         ovf_in   = ovf_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lwt_pkg::PH_START;
         words_ff <= '0;
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         words_ff <= words_in;
         pos_ff   <= pos_in;
         ovf_ff   <= ovf_in;
      end
   end

   // results of this byte, packed to the front in order
   always_comb begin
      logic [31:0]           words_x, words_mid_x, words_end_x, pos_x, pos_mid_x, start_x;
      lwt_pkg::rsp_item_type ra, rb, rc;
      logic [1:0]            n;

      words_x     = 32'(words_ff);
      words_mid_x = 32'(words_mid);
      words_end_x = 32'(words_end);
      pos_x       = 32'(pos_ff);
      pos_mid_x   = 32'(pos_mid);
      start_x     = 32'(pos_start);

      ra = '0;
      if (end_sep) begin
         ra.kind          = lwt_pkg::KIND_WORD_END;
         ra.word_index    = words_x[6:0];
         ra.char_position = pos_x[8:0];
      end else begin
         ra.kind          = lwt_pkg::KIND_WORD_BYTE;
         ra.word_byte     = tok.text_byte;
         ra.word_index    = words_x[6:0];
         ra.char_position = start_x[8:0];
      end
      ra.last = !end_last && !tok.line_last;

      rb               = '0;
      rb.kind          = lwt_pkg::KIND_WORD_END;
      rb.word_index    = words_mid_x[6:0];
      rb.char_position = pos_mid_x[8:0];
      rb.last          = !tok.line_last;

      rc            = '0;
      rc.kind       = lwt_pkg::KIND_LINE_END;
      rc.word_total = words_end_x[7:0];
      rc.overflow   = ovf_mid;
      rc.last       = 1'b1;

      burst = '0;
      n     = 2'd0;
      if (end_sep || byte_emit) begin
         burst.item[n] = ra;
         n = n + 2'd1;
      end
      if (end_last) begin
         burst.item[n] = rb;
         n = n + 2'd1;
      end
      if (tok.line_last) begin
         burst.item[n] = rc;
         n = n + 2'd1;
      end
      burst.count = n;
   end

endmodule

>>> rtl/lwt_rsp_queue.sv
module lwt_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  lwt_pkg::burst_type    burst,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lwt_pkg::rsp_item_type head
);

   lwt_pkg::rsp_item_type [2:0] item_ff, item_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic                        pop;

   assign pop        = (cnt_ff != 2'd0) && rsp_tready;
   assign can_load   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign head       = item_ff[0];

   always_comb begin
      item_in = item_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         item_in = burst.item;
         cnt_in  = burst.count;
      end else if (pop) begin
         item_in[0] = item_ff[1];
         item_in[1] = item_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   a_last_on_final : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> item_ff[0].last)
      else $error("final queued result lacks last");

   a_no_early_last : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 || cnt_ff == 2'd3) |-> !item_ff[0].last)
      else $error("last set before the final result");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("burst loaded over pending results");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (pop && !load) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("queue count not decremented on transfer");

endmodule

>>> rtl/line_word_tokenizer.sv
// a result passes from its byte transfer through the input register and the result queue
// throughput: one byte per cycle while rsp_tready is high and each byte gives at most one
// result; a byte giving k results (up to three) holds the single result port until all k leave
// zero-result bytes (gaps, ignored text) pass through without using the result port
// reset: synchronous, clears line state and queue, loads separator and comment defaults
module line_word_tokenizer #(
   parameter int MAX_WORDS       = 128,
   parameter int WORD_CHARS      = 512,
   parameter int SEPARATOR_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // line_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // word_byte, word_index, char_position, word_total, overflow
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last result of the byte
);

   logic [2:0] sep_count_ff;
   logic [7:0] sep_ff [lwt_pkg::SEP_REGS];
   logic [7:0] comment_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                  is_sep, is_com, consume, can_load, load;
   lwt_pkg::tok_type      tok;
   lwt_pkg::burst_type    burst;
   lwt_pkg::rsp_item_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_count_ff <= lwt_pkg::SEP_COUNT_RESET;
         sep_ff[0]    <= lwt_pkg::SEP_A_RESET;
         sep_ff[1]    <= lwt_pkg::SEP_B_RESET;
         sep_ff[2]    <= lwt_pkg::SEP_C_RESET;
         sep_ff[3]    <= lwt_pkg::SEP_D_RESET;
         comment_ff   <= lwt_pkg::COMMENT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            lwt_pkg::CSR_SEP_COUNT: sep_count_ff <= csr_wdata[2:0];
            lwt_pkg::CSR_SEP_A:     sep_ff[0]    <= csr_wdata;
            lwt_pkg::CSR_SEP_B:     sep_ff[1]    <= csr_wdata;
            lwt_pkg::CSR_SEP_C:     sep_ff[2]    <= csr_wdata;
            lwt_pkg::CSR_SEP_D:     sep_ff[3]    <= csr_wdata;
            lwt_pkg::CSR_COMMENT:   comment_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register: refilled in the same cycle it is drained
   assign req_tready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (consume) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   lwt_sep_match #(
      .SEPARATOR_SLOTS(SEPARATOR_SLOTS)
   ) u_match (
      .text_byte   (in_byte_ff),
      .sep_count   (sep_count_ff),
      .sep_bytes   (sep_ff),
      .comment_byte(comment_ff),
      .is_sep      (is_sep),
      .is_com      (is_com)
   );

   assign tok.text_byte = in_byte_ff;
   assign tok.line_last = in_last_ff;
   assign tok.is_sep    = is_sep;
   assign tok.is_com    = is_com;

   lwt_line_fsm #(
      .MAX_WORDS (MAX_WORDS),
      .WORD_CHARS(WORD_CHARS)
   ) u_fsm (
      .clock(clock),
      .reset(reset),
      .step (consume),
      .tok  (tok),
      .burst(burst)
   );

   // bytes with no result never wait on the output side
   assign consume = in_valid_ff && ((burst.count == 2'd0) || can_load);
   assign load    = consume && (burst.count != 2'd0);

   lwt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .head      (head)
   );

   assign rsp_tdata = {7'b0, head.overflow, head.word_total, head.char_position,
                       head.word_index, head.word_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

>>> dv/line_word_tokenizer_test.sv
`timescale 1ns / 1ps

module line_word_tokenizer_test;

   localparam int MAX_WORDS  = 128;
   localparam int WORD_CHARS = 512;

   typedef struct {
      logic [7:0] text;
      logic       line_end;
   } text_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   line_word_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_item_type         text_queue[$];
   lwt_pkg::rsp_item_type token_queue[$];
   lwt_pkg::rsp_item_type step_out[$];
   text_item_type         next_text;
   int                    mismatches = 0;
   bit                    steady = 1'b0;

   // configuration copy
   logic [2:0] cfg_count;
   logic [7:0] cfg_seps[lwt_pkg::SEP_REGS];
   logic [7:0] cfg_comment;

   // line state
   lwt_pkg::phase_type ph;
   int                 words_done;
   int                 word_len;
   bit                 line_ovf;

   function automatic bit is_split(input logic [7:0] b);
      int used;
      used = (cfg_count > lwt_pkg::SEP_REGS) ? lwt_pkg::SEP_REGS : int'(cfg_count);
      for (int i = 0; i < used; i++)
         if (cfg_seps[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic lwt_pkg::rsp_item_type make_result(input logic [1:0] kind,
                                                         input logic [7:0] b,
                                                         input int idx, input int pos,
                                                         input int total, input bit ovf);
      lwt_pkg::rsp_item_type r;
      r = '0;
      r.kind          = kind;
      r.word_byte     = b;
      r.word_index    = idx[6:0];
      r.char_position = pos[8:0];
      r.word_total    = total[7:0];
      r.overflow      = ovf;
      return r;
   endfunction

   task automatic close_word();
      if (words_done < MAX_WORDS) begin
         step_out.push_back(make_result(lwt_pkg::KIND_WORD_END, 8'd0, words_done, word_len,
                                        0, 1'b0));
         words_done++;
      end
      word_len = 0;
   endtask

   task automatic clear_line();
      ph         = lwt_pkg::PH_START;
      words_done = 0;
      word_len   = 0;
      line_ovf   = 1'b0;
   endtask

   task automatic tokenize_byte(input logic [7:0] b, input logic lastf);
      bit sep;
      bit com;
      sep = is_split(b);
      com = (b == cfg_comment);
      step_out.delete();
      if (ph == lwt_pkg::PH_IGNORE) begin
         // rest of line skipped
      end else if (ph == lwt_pkg::PH_START && com) begin
         ph = lwt_pkg::PH_IGNORE;
      end else if (sep) begin
         if (ph == lwt_pkg::PH_WORD) close_word();
         ph = lwt_pkg::PH_GAP;
      end else if (com) begin
         // unfinished word dropped without a word end
         word_len = 0;
         ph = lwt_pkg::PH_IGNORE;
      end else begin
         if (ph != lwt_pkg::PH_WORD) begin
            ph = lwt_pkg::PH_WORD;
            word_len = 0;
         end
         if (words_done >= MAX_WORDS || word_len >= WORD_CHARS - 1) begin
            line_ovf = 1'b1;
         end else begin
            step_out.push_back(make_result(lwt_pkg::KIND_WORD_BYTE, b, words_done, word_len,
                                           0, 1'b0));
            word_len++;
         end
      end
      if (lastf) begin
         if (ph == lwt_pkg::PH_WORD) close_word();
         step_out.push_back(make_result(lwt_pkg::KIND_LINE_END, 8'd0, 0, 0, words_done,
                                        line_ovf));
         clear_line();
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) token_queue.push_back(step_out[i]);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) tokenize_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (text_queue.size() > 0 && (steady || $urandom_range(99) >= 10)) begin
               next_text = text_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_text.text;
               req_tlast  <= next_text.line_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_result();
      lwt_pkg::rsp_item_type got;
      lwt_pkg::rsp_item_type want;
      got.kind          = rsp_tuser;
      got.word_byte     = rsp_tdata[7:0];
      got.word_index    = rsp_tdata[14:8];
      got.char_position = rsp_tdata[23:15];
      got.word_total    = rsp_tdata[31:24];
      got.overflow      = rsp_tdata[32];
      got.last          = rsp_tlast;
      if (token_queue.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: kind %0d byte %h word %0d pos %0d total %0d ovf %b",
                     got.kind, got.word_byte, got.word_index, got.char_position,
                     got.word_total, got.overflow);
      end else begin
         want = token_queue.pop_front();
         if (got !== want || rsp_tdata[39:33] !== 7'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: want kind %0d byte %h word %0d pos %0d total %0d ovf %b last %b",
                        want.kind, want.word_byte, want.word_index, want.char_position,
                        want.word_total, want.overflow, want.last);
               $display("          got kind %0d byte %h word %0d pos %0d total %0d ovf %b last %b",
                        got.kind, got.word_byte, got.word_index, got.char_position,
                        got.word_total, got.overflow, got.last);
               $display("          got pad %h", rsp_tdata[39:33]);
            end
         end
      end
   endtask

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= steady || ($urandom_range(99) >= 10);
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic l);
      text_item_type t;
      t.text     = b;
      t.line_end = l;
      text_queue.push_back(t);
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 25) return cfg_seps[$urandom_range(lwt_pkg::SEP_REGS - 1)];
      if (r < 30) return cfg_comment;
      if (r < 40) return r[0] ? 8'h00 : 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   task automatic add_lines(input int n);
      int total;
      int len;
      total = 0;
      while (total < n) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) add_byte(pick_byte(), i == len - 1);
         total += len;
      end
   endtask

   // wait for the block to drain, including bytes that give no result
   task automatic settle();
      while (text_queue.size() != 0 || req_tvalid || token_queue.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         lwt_pkg::CSR_SEP_COUNT: cfg_count   = val[2:0];
         lwt_pkg::CSR_SEP_A:     cfg_seps[0] = val;
         lwt_pkg::CSR_SEP_B:     cfg_seps[1] = val;
         lwt_pkg::CSR_SEP_C:     cfg_seps[2] = val;
         lwt_pkg::CSR_SEP_D:     cfg_seps[3] = val;
         lwt_pkg::CSR_COMMENT:   cfg_comment = val;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      cfg_count   = lwt_pkg::SEP_COUNT_RESET;
      cfg_seps[0] = lwt_pkg::SEP_A_RESET;
      cfg_seps[1] = lwt_pkg::SEP_B_RESET;
      cfg_seps[2] = lwt_pkg::SEP_C_RESET;
      cfg_seps[3] = lwt_pkg::SEP_D_RESET;
      cfg_comment = lwt_pkg::COMMENT_RESET;
      clear_line();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults: comment line, plain words, separators only, zero byte,
      // mid-line comment, trailing separator, comment as final byte
      add_byte("#", 1'b0);   add_byte("x", 1'b1);
      add_byte("a", 1'b0);   add_byte("b", 1'b0);   add_byte(" ", 1'b0);
      add_byte("c", 1'b0);   add_byte("d", 1'b1);
      add_byte(8'h09, 1'b0); add_byte(8'h0A, 1'b1);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b0); add_byte("#", 1'b0);   add_byte("z", 1'b1);
      add_byte(" ", 1'b0);   add_byte("w", 1'b0);   add_byte(" ", 1'b1);
      add_byte("k", 1'b0);   add_byte("#", 1'b1);
      add_lines(45);
      settle();

      // no separators, zero byte is the comment character
      write_reg(lwt_pkg::CSR_SEP_COUNT, 8'd0);
      write_reg(lwt_pkg::CSR_COMMENT, 8'h00);
      end_writes();
      add_byte(8'h00, 1'b0); add_byte(" ", 1'b1);
      add_byte("p", 1'b0);   add_byte(" ", 1'b0);   add_byte(8'h00, 1'b1);
      add_lines(35);
      settle();

      // all four slots, comment byte also a separator
      write_reg(lwt_pkg::CSR_SEP_COUNT, 8'd4);
      write_reg(lwt_pkg::CSR_SEP_A, "a");
      write_reg(lwt_pkg::CSR_SEP_B, 8'hFF);
      write_reg(lwt_pkg::CSR_SEP_C, 8'h00);
      write_reg(lwt_pkg::CSR_SEP_D, 8'h80);
      write_reg(lwt_pkg::CSR_COMMENT, "a");
      end_writes();
      add_byte("a", 1'b0);   add_byte("q", 1'b1);
      add_byte("x", 1'b0);   add_byte("a", 1'b0);   add_byte(8'h80, 1'b0);
      add_byte("y", 1'b1);
      add_lines(45);
      settle();

      // count above the slot number, both sides without gaps
      write_reg(lwt_pkg::CSR_SEP_COUNT, 8'd7);
      write_reg(lwt_pkg::CSR_SEP_D, 8'h2C);
      write_reg(lwt_pkg::CSR_COMMENT, 8'hFF);
      end_writes();
      steady = 1'b1;
      add_lines(55);
      settle();
      steady = 1'b0;

      write_reg(lwt_pkg::CSR_SEP_COUNT, lwt_pkg::SEP_COUNT_RESET);
      write_reg(lwt_pkg::CSR_SEP_A, lwt_pkg::SEP_A_RESET);
      write_reg(lwt_pkg::CSR_SEP_B, lwt_pkg::SEP_B_RESET);
      write_reg(lwt_pkg::CSR_SEP_C, lwt_pkg::SEP_C_RESET);
      write_reg(lwt_pkg::CSR_SEP_D, lwt_pkg::SEP_D_RESET);
      write_reg(lwt_pkg::CSR_COMMENT, lwt_pkg::COMMENT_RESET);
      end_writes();
      add_lines(40);
      settle();

      if (mismatches == 0 && token_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
